// File: rtl/core/pjet_pkg.sv
`timescale 1ns / 1ps

package pjet_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_C_REAL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREV_COEF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_ORIGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_SQ   = 3'd7;

  // Register reset values.
  localparam logic signed [31:0] RST_C_REAL      = 32'sd9505971;
  localparam logic signed [31:0] RST_C_IMAG      = 32'sd0;
  localparam logic signed [31:0] RST_PREV_COEF   = -32'sd8053064;
  localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd13106361;
  localparam logic signed [31:0] RST_IMAG_ORIGIN = 32'sd28051505;
  localparam logic [30:0]        RST_PIXEL_STEP  = 31'd41943;
  localparam logic [7:0]         RST_MAX_ITER    = 8'd100;
  localparam logic [30:0]        RST_ESCAPE_SQ   = 31'd150994944;

  // Width of the sums that form coordinates before saturation.
  localparam int ACC_W = 66;

  // The colour band that shows the magnitude of the final point.
  localparam logic [7:0] K_MAG_LO = 8'd30;
  localparam logic [7:0] K_MAG_HI = 8'd35;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_COL,
    ST_Y,
    ST_XX,
    ST_YY,
    ST_XY,
    ST_PX,
    ST_PY,
    ST_UPD,
    ST_SQ_ISSUE,
    ST_SQ_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] res;
    if (v > $signed({{(ACC_W-31){1'b0}}, {31{1'b1}}})) begin
      res = {1'b0, {31{1'b1}}};
    end else if (v < $signed({{(ACC_W-31){1'b1}}, {31{1'b0}}})) begin
      res = {1'b1, {31{1'b0}}};
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic [7:0] sat255(input logic [10:0] v);
    return (v > 11'd255) ? 8'hFF : v[7:0];
  endfunction

  // Banded colour map; mag is the integer magnitude of the final point.
  function automatic rgb_t colour_map(input logic [7:0] k, input logic [7:0] mag);
    logic [10:0] kk;
    logic [10:0] r;
    logic [10:0] g;
    logic [10:0] b;
    rgb_t c;
    kk = {3'b000, k};
    if (kk < 11'd10) begin
      r = 11'd15 * kk;
      g = 11'd15 * kk;
      b = 11'd25 * kk;
    end else if (kk < 11'd19) begin
      r = 11'd295 - 11'd15 * kk;
      g = 11'd285 - 11'd15 * kk;
      b = 11'd475 - 11'd25 * kk;
    end else if (kk < 11'd30) begin
      r = kk << 1;
      g = kk >> 1;
      b = 11'd0;
    end else if (kk < 11'd35) begin
      r = {3'b000, mag};
      g = kk << 1;
      b = kk >> 1;
    end else if (kk < 11'd45) begin
      r = kk << 1;
      g = kk;
      b = kk >> 1;
    end else if (kk < 11'd55) begin
      r = kk >> 1;
      g = kk << 1;
      b = kk;
    end else if (kk < 11'd65) begin
      r = kk >> 1;
      g = kk;
      b = kk << 1;
    end else begin
      r = 11'd85;
      g = 11'd80;
      b = (11'd5 * kk) >> 1;
    end
    c.red   = sat255(r);
    c.green = sat255(g);
    c.blue  = sat255(b);
    return c;
  endfunction

endpackage

// File: rtl/core/pjet_mul.sv
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product.
module pjet_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

// File: rtl/core/phoenix_julia_escape_time_pixel.sv
`timescale 1ns / 1ps

// A new input beat is taken only while the sequencer is idle. Where k is the final iteration
// count, the band 30 <= k < 35 adds a search for the root; every multiply of the start point,
// the recurrence and the root runs through one registered 32x32 multiplier.
// Reset (rst, synchronous, active high) returns the sequencer to idle, drops the result
// beat and loads every configuration register with its default value.
module phoenix_julia_escape_time_pixel
  import pjet_pkg::*;
#(
  parameter int COORD_BITS = 11,
  parameter int FRAC_BITS  = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_data,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // column [COORD_BITS-1:0], row [2*COORD_BITS-1:COORD_BITS], zero padding above
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // iterations [7:0], red [15:8], green [23:16], blue [31:24]
  output logic [31:0]                            m_tdata
);

  // The integer magnitude is isqrt(|z|^2 >> 2*FRAC_BITS), a root of ROOT_BITS bits that is
  // found one bit per trial square on the shared multiplier.
  localparam int ROOT_BITS = 32 - FRAC_BITS;
  localparam int BIT_IDX_W = $clog2(ROOT_BITS);

  // Configuration registers.
  logic signed [31:0] c_real;
  logic signed [31:0] c_imag;
  logic signed [31:0] prev_coef;
  logic signed [31:0] real_origin;
  logic signed [31:0] imag_origin;
  logic [30:0]        pixel_step;
  logic [7:0]         max_iter;
  logic [30:0]        escape_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real      <= RST_C_REAL;
      c_imag      <= RST_C_IMAG;
      prev_coef   <= RST_PREV_COEF;
      real_origin <= RST_REAL_ORIGIN;
      imag_origin <= RST_IMAG_ORIGIN;
      pixel_step  <= RST_PIXEL_STEP;
      max_iter    <= RST_MAX_ITER;
      escape_sq   <= RST_ESCAPE_SQ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_C_REAL:      c_real      <= cfg_data;
        CFG_C_IMAG:      c_imag      <= cfg_data;
        CFG_PREV_COEF:   prev_coef   <= cfg_data;
        CFG_REAL_ORIGIN: real_origin <= cfg_data;
        CFG_IMAG_ORIGIN: imag_origin <= cfg_data;
        CFG_PIXEL_STEP:  pixel_step  <= cfg_data[30:0];
        CFG_MAX_ITER:    max_iter    <= cfg_data[7:0];
        CFG_ESCAPE_SQ:   escape_sq   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and the working registers of one pixel.
  state_t state;
  state_t state_next;

  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;
  logic signed [31:0]    x;
  logic signed [31:0]    y;
  logic signed [31:0]    px;
  logic signed [31:0]    py;
  logic signed [31:0]    nxr;
  logic signed [63:0]    sqx;
  logic [63:0]           mag;
  logic signed [ACC_W-1:0] diff;
  logic signed [ACC_W-1:0] accy;
  logic [7:0]            k;
  logic [ROOT_BITS-1:0]  root;
  logic [BIT_IDX_W-1:0]  bit_idx;

  // Shared multiplier; its product shows up in the cycle after the operands.
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;

  pjet_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  logic [ROOT_BITS-1:0] trial;
  assign trial = root | (ROOT_BITS'(1) << bit_idx);

  always_comb begin
    unique case (state)
      ST_ROW: begin
        mul_a = 32'(row_r);
        mul_b = {1'b0, pixel_step};
      end
      ST_COL: begin
        mul_a = 32'(col_r);
        mul_b = {1'b0, pixel_step};
      end
      ST_XX: begin
        mul_a = x;
        mul_b = x;
      end
      ST_YY: begin
        mul_a = y;
        mul_b = y;
      end
      ST_XY: begin
        mul_a = x;
        mul_b = y;
      end
      ST_PX: begin
        mul_a = prev_coef;
        mul_b = px;
      end
      ST_PY: begin
        mul_a = prev_coef;
        mul_b = py;
      end
      ST_SQ_ISSUE: begin
        mul_a = 32'(trial);
        mul_b = 32'(trial);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Product and operands widened for the saturating sums. A right shift of the signed
  // product truncates toward minus infinity, as the fixed-point format requires.
  logic signed [ACC_W-1:0] prod_w;
  logic signed [ACC_W-1:0] sqx_w;
  logic signed [ACC_W-1:0] prod_f;
  logic signed [ACC_W-1:0] prod_f1;

  assign prod_w  = {{(ACC_W-64){prod[63]}}, prod};
  assign sqx_w   = {{(ACC_W-64){sqx[63]}}, sqx};
  assign prod_f  = prod_w >>> FRAC_BITS;
  assign prod_f1 = prod_w >>> (FRAC_BITS - 1);

  // The loop runs on while the count is under the limit and the point has not escaped.
  logic keep_going;
  logic in_mag_band;
  logic slot_free;
  logic root_fits;

  assign keep_going  = (k < max_iter) && ((mag >> FRAC_BITS) < {33'd0, escape_sq});
  assign in_mag_band = (k >= K_MAG_LO) && (k < K_MAG_HI);
  assign slot_free   = !m_tvalid || m_tready;
  assign root_fits   = $unsigned(prod) <= (mag >> (2 * FRAC_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_ROW;
        end
      end
      ST_ROW:  state_next = ST_COL;
      ST_COL:  state_next = ST_Y;
      ST_Y:    state_next = ST_XX;
      ST_XX:   state_next = ST_YY;
      ST_YY:   state_next = ST_XY;
      ST_XY:   state_next = ST_PX;
      ST_PX: begin
        if (keep_going) begin
          state_next = ST_PY;
        end else if (in_mag_band) begin
          state_next = ST_SQ_ISSUE;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_PY:       state_next = ST_UPD;
      ST_UPD:      state_next = ST_XX;
      ST_SQ_ISSUE: state_next = ST_SQ_CMP;
      ST_SQ_CMP: begin
        if (bit_idx == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SQ_ISSUE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath. Each state takes in the product of the multiply issued one state earlier.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      col_r <= s_tdata[COORD_BITS-1:0];
      row_r <= s_tdata[2*COORD_BITS-1:COORD_BITS];
    end
    unique case (state)
      ST_COL: begin
        x <= sat32({{(ACC_W-32){real_origin[31]}}, real_origin} + prod_w);
      end
      ST_Y: begin
        y  <= sat32({{(ACC_W-32){imag_origin[31]}}, imag_origin} - prod_w);
        px <= '0;
        py <= '0;
        k  <= 8'd1;
      end
      ST_YY: begin
        sqx <= prod;
      end
      ST_XY: begin
        // The squares are both non-negative, so |z|^2 cannot overflow 64 bits.
        mag  <= $unsigned(sqx) + $unsigned(prod);
        diff <= (sqx_w >>> FRAC_BITS) - prod_f + {{(ACC_W-32){c_real[31]}}, c_real};
      end
      ST_PX: begin
        accy    <= prod_f1 + {{(ACC_W-32){c_imag[31]}}, c_imag};
        root    <= '0;
        bit_idx <= BIT_IDX_W'(ROOT_BITS - 1);
      end
      ST_PY: begin
        nxr <= sat32(diff + prod_f);
      end
      ST_UPD: begin
        y  <= sat32(accy + prod_f);
        x  <= nxr;
        px <= x;
        py <= y;
        k  <= k + 8'd1;
      end
      ST_SQ_CMP: begin
        if (root_fits) begin
          root <= trial;
        end
        bit_idx <= bit_idx - BIT_IDX_W'(1);
      end
      default: ;
    endcase
  end

  // Output register; it holds the result beat while the next pixel is being worked on.
  logic [7:0] mag_int;
  rgb_t       colour;

  assign mag_int = (32'(root) > 32'd255) ? 8'hFF : 8'(root);
  assign colour  = colour_map(k, mag_int);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && slot_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && slot_free) begin
      m_tdata <= {colour.blue, colour.green, colour.red, k};
    end
  end

`ifndef SYNTHESIS
  // A result beat only starts from the final state of the sequencer.
  a_result_from_done : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result beat raised outside the final state");

  // A finished pixel must wait while the previous result is still stalled.
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && m_tvalid && !m_tready) |=> (state == ST_DONE && $stable(m_tdata)))
    else $error("pending result overwritten");

  // The root is built from the top bit down: bits at and below the trial bit are still clear.
  a_root_order : assert property (@(posedge clk) disable iff (rst)
    state == ST_SQ_ISSUE |->
      (root & ((ROOT_BITS'(2) << bit_idx) - ROOT_BITS'(1))) == '0)
    else $error("root bits set out of order");
`endif

endmodule
